>>> rtl/encoder_linearization_table_builder_assert.svh
`ifndef ENCODER_LINEARIZATION_TABLE_BUILDER_ASSERT_SVH
`define ENCODER_LINEARIZATION_TABLE_BUILDER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ELTB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("eltb: same-cycle check failed");

// next-cycle implication
`define ELTB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("eltb: next-cycle check failed");

`endif

>>> rtl/eltb_pkg.sv
package eltb_pkg;

    localparam int ENC_COUNTS  = 16384;
    localparam int FULL_STEPS  = 200;
    localparam int STORE_DEPTH = FULL_STEPS + 1;
    localparam int MICROSTEPS  = 256;
    localparam int MS_SHIFT    = $clog2(MICROSTEPS);
    localparam int POS_TURN    = 51200;
    localparam int NOM_COUNTS  = ENC_COUNTS / FULL_STEPS;
    localparam int DELTA_HI    = NOM_COUNTS * 3 / 2;
    localparam int DELTA_LO    = NOM_COUNTS * 1 / 2;
    localparam int HALF_LO     = ENC_COUNTS / 2;
    localparam int HALF_UP     = (ENC_COUNTS + 1) / 2;
    localparam int VAL_W       = 14;
    localparam int NUM_W       = VAL_W + MS_SHIFT;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_DIR   = 3'd1,
        ERR_CONT  = 3'd2,
        ERR_WRAP  = 3'd3,
        ERR_COUNT = 3'd4
    } t_err;

    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] fwd_value;
        logic [VAL_W-1:0] bwd_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] entry;
        logic        entry_valid;
        logic        last_entry;
        logic        check_done;
        logic [2:0]  error_code;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
        logic [5:0]  count;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [15:0] remainder;
    } t_div_rsp;

    // signed circular difference a - b, folded into one half turn
    function automatic logic signed [14:0] cyc_diff(input logic [VAL_W-1:0] a,
                                                    input logic [VAL_W-1:0] b);
        logic signed [15:0] d;
        d = $signed({2'b00, a}) - $signed({2'b00, b});
        if (d > $signed(16'(HALF_LO))) d = d - $signed(16'(ENC_COUNTS));
        if (d < -$signed(16'(HALF_UP))) d = d + $signed(16'(ENC_COUNTS));
        return d[14:0];
    endfunction

    function automatic logic [VAL_W-1:0] cyc_mean(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] spread;
        logic [VAL_W:0]   sum;
        logic [VAL_W-1:0] m;
        spread = (a > b) ? a - b : b - a;
        sum    = {1'b0, a} + {1'b0, b};
        m      = sum[VAL_W:1];
        if (spread > VAL_W'(HALF_LO)) begin
            m = (m >= VAL_W'(HALF_LO)) ? m - VAL_W'(HALF_LO) : m + VAL_W'(HALF_LO);
        end
        return m;
    endfunction

    // x is at most 2*FULL_STEPS
    function automatic logic [7:0] mod_fs(input logic [8:0] x);
        logic [8:0] r;
        if (x >= 9'(2 * FULL_STEPS)) r = x - 9'(2 * FULL_STEPS);
        else if (x >= 9'(FULL_STEPS)) r = x - 9'(FULL_STEPS);
        else r = x;
        return r[7:0];
    endfunction

endpackage

>>> rtl/encoder_linearization_table_builder.sv
// Encoder linearization table builder.
// Command channel: an item (i_cmd) transfers on a rising edge with start high
// and busy low. A load item (func 0) stores the circular mean of one forward /
// backward reading pair; FULL_STEPS+1 loads make a run. A fetch item (func 1)
// returns the next encoder-count-to-microstep table entry once a run has passed its check.
// Result channel: every item gives exactly one result on o_res, strobed by
// o_res_valid for one cycle; the receiver cannot stall it.
// Timing: an ordinary load answers in the cycle after its transfer and busy
// stays low, so loads can follow back to back. The last load of a run walks
// the sample memory to check the sweep, then locates the first table entry,
// skipping empty steps; a failed check answers earlier.
// A fetch runs the shift-subtract divider, reduces the position modulo one turn
// by compare and subtract, then reads the two samples of its step, advancing
// past steps that have no entries left, and gives its result; the next item
// can transfer once busy falls with that result.
// busy is high throughout.
// Reset: synchronous, active low; the run restarts in the loading phase. The
// sample memory is not cleared; every entry is written before it is read.
`include "encoder_linearization_table_builder_assert.svh"

module encoder_linearization_table_builder
    import eltb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_cmd,
    output logic      busy,
    output logic      o_res_valid,
    output t_out_item o_res
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_C0A  = 11'b000_0000_0010,
        S_C0B  = 11'b000_0000_0100,
        S_C0E  = 11'b000_0000_1000,
        S_C1A  = 11'b000_0001_0000,
        S_C1E  = 11'b000_0010_0000,
        S_C2   = 11'b000_0100_0000,
        S_NA   = 11'b000_1000_0000,
        S_NB   = 11'b001_0000_0000,
        S_NE   = 11'b010_0000_0000,
        S_DVW  = 11'b100_0000_0000
    } t_state;

    typedef enum logic [2:0] {
        PH_LOADING  = 3'b001,
        PH_EMITTING = 3'b010,
        PH_DONE     = 3'b100
    } t_phase;

    logic [VAL_W-1:0] mem [STORE_DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    logic [7:0]       mem_waddr;
    logic [7:0]       mem_raddr;

    t_state           r_state,     n_state;
    t_phase           r_phase,     n_phase;
    t_err             r_err,       n_err;
    logic [7:0]       r_idx,       n_idx;
    logic             r_rising,    n_rising;
    logic [7:0]       r_wrap_step, n_wrap_step;
    logic [VAL_W-1:0] r_wrap_off,  n_wrap_off;
    logic [8:0]       r_step,      n_step;
    logic [VAL_W-1:0] r_sub,       n_sub;
    logic [15:0]      r_count,     n_count;
    logic [VAL_W-1:0] r_prev,      n_prev;
    logic [VAL_W-1:0] r_s0,        n_s0;
    logic [VAL_W-1:0] r_a,         n_a;
    logic [7:0]       r_c,         n_c;
    logic [1:0]       r_hits,      n_hits;
    logic [VAL_W-1:0] r_delta,     n_delta;
    logic             r_fetch,     n_fetch;
    logic [15:0]      r_entry,     n_entry;
    t_out_item        r_res,       n_res;
    logic             r_res_valid, n_res_valid;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    logic             accept;
    logic [7:0]       ld_idx;
    t_err             ld_err;
    logic [VAL_W-1:0] ld_mean;
    logic [8:0]       x_cur;
    logic [7:0]       addr_a;
    logic [7:0]       addr_b;
    logic signed [14:0] d_chk;
    logic [14:0]      d_abs;
    logic [VAL_W-1:0] w_cur;
    logic [VAL_W-1:0] w_nxt;
    logic             w_hit;
    logic [VAL_W-1:0] w_off;
    logic             one_hit;
    logic signed [14:0] d_step;
    logic [VAL_W-1:0] d_pos;
    logic [VAL_W-1:0] top;
    logic [NUM_W-1:0] frac;
    logic [31:0]      pos_raw;
    logic [31:0]      pos_mod;
    logic             fin_ex;
    logic             fin_err4;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign ld_idx  = (r_phase == PH_DONE) ? 8'd0 : r_idx;
    assign ld_err  = (r_phase == PH_DONE) ? ERR_NONE : r_err;
    assign ld_mean = cyc_mean(i_cmd.fwd_value, i_cmd.bwd_value);

    // table step for the current emit position, and its two sample addresses
    assign x_cur  = r_rising ? 9'(r_wrap_step) + r_step
                             : 9'(r_wrap_step) + 9'(FULL_STEPS) - r_step;
    assign addr_a = mod_fs(x_cur);
    assign addr_b = mod_fs(x_cur + 9'd1);

    assign d_chk = cyc_diff(r_rdata, r_prev);
    assign d_abs = (d_chk < 15'sd0) ? 15'(-d_chk) : 15'(d_chk);

    // wrap point test on the pair (previous sample, this sample)
    assign w_cur   = r_prev;
    assign w_nxt   = (r_state == S_C2) ? r_s0 : r_rdata;
    assign w_hit   = r_rising ? (w_nxt < w_cur) : (w_nxt > w_cur);
    assign w_off   = VAL_W'(ENC_COUNTS - 1) - (r_rising ? w_cur : w_nxt);
    assign one_hit = (r_hits == 2'd1 && !w_hit) || (r_hits == 2'd0 && w_hit);

    assign d_step = r_rising ? cyc_diff(r_rdata, r_a) : cyc_diff(r_a, r_rdata);
    assign d_pos  = (d_step > 15'sd0) ? VAL_W'(d_step) : '0;
    assign top    = (d_pos == '0) ? '0
                  : ((r_step == 9'(FULL_STEPS)) ? r_wrap_off : d_pos);

    assign frac    = (r_delta == '0) ? '0 : div_rsp.quotient[NUM_W-1:0];
    assign pos_raw = r_rising ? (32'(x_cur) << MS_SHIFT) + 32'(frac)
                              : (32'(x_cur + 9'd1) << MS_SHIFT) - 32'(frac);
    // pos_raw stays below two turns plus one step
    assign pos_mod = (pos_raw >= 32'(2 * POS_TURN)) ? pos_raw - 32'(2 * POS_TURN)
                   : (pos_raw >= 32'(POS_TURN))     ? pos_raw - 32'(POS_TURN)
                   : pos_raw;

    assign fin_ex   = (r_sub >= top);
    assign fin_err4 = (r_count != 16'(ENC_COUNTS));

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_err       = r_err;
        n_idx       = r_idx;
        n_rising    = r_rising;
        n_wrap_step = r_wrap_step;
        n_wrap_off  = r_wrap_off;
        n_step      = r_step;
        n_sub       = r_sub;
        n_count     = r_count;
        n_prev      = r_prev;
        n_s0        = r_s0;
        n_a         = r_a;
        n_c         = r_c;
        n_hits      = r_hits;
        n_delta     = r_delta;
        n_fetch     = r_fetch;
        n_entry     = r_entry;
        n_res       = r_res;
        n_res_valid = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = ld_idx;
        mem_raddr   = '0;
        div_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res            = '0;
                    n_res.error_code = r_err;
                    if (i_cmd.func == FUNC_LOAD) begin
                        if (r_phase == PH_EMITTING) begin
                            n_res_valid = 1'b1;
                        end else begin
                            n_phase          = PH_LOADING;
                            n_err            = ld_err;
                            n_res.error_code = ld_err;
                            mem_we           = 1'b1;
                            n_idx            = ld_idx + 8'd1;
                            if (ld_idx == 8'(STORE_DEPTH - 1)) begin
                                n_state = S_C0A;
                            end else begin
                                n_res_valid = 1'b1;
                            end
                        end
                    end else if (r_phase == PH_EMITTING) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {r_sub, {(32 - VAL_W){1'b0}}};
                        div_req.divisor  = 16'(r_delta);
                        div_req.count    = 6'(NUM_W);
                        n_count          = r_count + 16'd1;
                        n_state          = S_DVW;
                    end else begin
                        n_res_valid = 1'b1;
                    end
                end
            end
            S_C0A: begin
                mem_raddr = 8'(FULL_STEPS - 1);
                n_state   = S_C0B;
            end
            S_C0B: begin
                mem_raddr = '0;
                n_prev    = r_rdata;
                n_state   = S_C0E;
            end
            S_C0E: begin
                if (d_chk == 15'sd0) begin
                    n_state          = S_IDLE;
                    n_phase          = PH_DONE;
                    n_err            = ERR_DIR;
                    n_res_valid      = 1'b1;
                    n_res            = '0;
                    n_res.check_done = 1'b1;
                    n_res.error_code = ERR_DIR;
                end else begin
                    n_rising = (d_chk > 15'sd0);
                    n_s0     = r_rdata;
                    n_prev   = r_rdata;
                    n_c      = 8'd1;
                    n_hits   = '0;
                    n_state  = S_C1A;
                end
            end
            S_C1A: begin
                mem_raddr = r_c;
                n_state   = S_C1E;
            end
            S_C1E: begin
                if (d_abs > 15'(DELTA_HI) || d_abs < 15'(DELTA_LO)) begin
                    n_state          = S_IDLE;
                    n_phase          = PH_DONE;
                    n_err            = ERR_CONT;
                    n_res_valid      = 1'b1;
                    n_res            = '0;
                    n_res.check_done = 1'b1;
                    n_res.error_code = ERR_CONT;
                end else if (d_chk == 15'sd0 || ((d_chk > 15'sd0) != r_rising)) begin
                    n_state          = S_IDLE;
                    n_phase          = PH_DONE;
                    n_err            = ERR_DIR;
                    n_res_valid      = 1'b1;
                    n_res            = '0;
                    n_res.check_done = 1'b1;
                    n_res.error_code = ERR_DIR;
                end else begin
                    if (w_hit) begin
                        n_hits      = (r_hits == 2'd2) ? r_hits : r_hits + 2'd1;
                        n_wrap_step = r_c - 8'd1;
                        n_wrap_off  = w_off;
                    end
                    n_prev = r_rdata;
                    if (r_c == 8'(FULL_STEPS - 1)) begin
                        n_state = S_C2;
                    end else begin
                        n_c     = r_c + 8'd1;
                        n_state = S_C1A;
                    end
                end
            end
            S_C2: begin
                // closing pair: last sample back to the first
                if (!one_hit) begin
                    n_state          = S_IDLE;
                    n_phase          = PH_DONE;
                    n_err            = ERR_WRAP;
                    n_res_valid      = 1'b1;
                    n_res            = '0;
                    n_res.check_done = 1'b1;
                    n_res.error_code = ERR_WRAP;
                end else begin
                    if (w_hit) begin
                        n_wrap_step = 8'(FULL_STEPS - 1);
                        n_wrap_off  = w_off;
                        n_sub       = w_off;
                    end else begin
                        n_sub = r_wrap_off;
                    end
                    n_step  = '0;
                    n_count = '0;
                    n_fetch = 1'b0;
                    n_state = S_NA;
                end
            end
            S_NA: begin
                mem_raddr = addr_a;
                n_state   = S_NB;
            end
            S_NB: begin
                mem_raddr = addr_b;
                n_a       = r_rdata;
                n_state   = S_NE;
            end
            S_NE: begin
                if (!fin_ex || r_step == 9'(FULL_STEPS)) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    n_res       = '0;
                    if (fin_ex) begin
                        n_sub   = '0;
                        n_step  = r_step + 9'd1;
                        n_phase = PH_DONE;
                    end else begin
                        n_delta = d_pos;
                    end
                    if (!r_fetch) begin
                        n_res.check_done = 1'b1;
                        if (fin_ex) begin
                            n_err            = ERR_COUNT;
                            n_res.error_code = ERR_COUNT;
                        end else begin
                            n_phase          = PH_EMITTING;
                            n_res.error_code = r_err;
                        end
                    end else begin
                        n_res.entry       = r_entry;
                        n_res.entry_valid = 1'b1;
                        n_res.last_entry  = fin_ex;
                        if (fin_ex && fin_err4) begin
                            n_err            = ERR_COUNT;
                            n_res.error_code = ERR_COUNT;
                        end else begin
                            n_res.error_code = r_err;
                        end
                    end
                end else begin
                    n_sub   = '0;
                    n_step  = r_step + 9'd1;
                    n_state = S_NA;
                end
            end
            S_DVW: begin
                if (div_rsp.done) begin
                    n_entry = pos_mod[15:0];
                    n_sub   = r_sub + VAL_W'(1);
                    n_fetch = 1'b1;
                    n_state = S_NA;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= ld_mean;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_LOADING;
            r_err       <= ERR_NONE;
            r_idx       <= '0;
            r_rising    <= 1'b0;
            r_wrap_step <= '0;
            r_wrap_off  <= '0;
            r_step      <= '0;
            r_sub       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_idx       <= n_idx;
            r_rising    <= n_rising;
            r_wrap_step <= n_wrap_step;
            r_wrap_off  <= n_wrap_off;
            r_step      <= n_step;
            r_sub       <= n_sub;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev  <= n_prev;
        r_s0    <= n_s0;
        r_a     <= n_a;
        r_c     <= n_c;
        r_hits  <= n_hits;
        r_delta <= n_delta;
        r_fetch <= n_fetch;
        r_entry <= n_entry;
        r_res   <= n_res;
    end

    eltb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ELTB_ASSERT_NXT(a_accept_answers, start && !busy, busy || o_res_valid)
    `ELTB_ASSERT_IMP(a_result_when_idle, o_res_valid, !busy)
    `ELTB_ASSERT_IMP(a_entry_in_turn, o_res_valid && o_res.entry_valid, o_res.entry < 16'(POS_TURN))

endmodule

>>> rtl/eltb_div.sv
module eltb_div
    import eltb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_num;
    logic [15:0] r_rem;
    logic [15:0] r_div;
    logic [31:0] r_quo;

    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    // one restoring step per cycle, dividend enters MSB first
    assign trial = {r_rem, r_num[31]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= ge ? diff[15:0] : trial[15:0];
            r_quo <= {r_quo[30:0], ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> verif/tb.sv
module tb;
    import eltb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {PH_LOAD, PH_EMIT, PH_END} t_run_phase;

    typedef struct packed {
        t_in_item item;
        bit       calm;
    } t_pending;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_cmd;
    logic      busy;
    logic      o_res_valid;
    t_out_item o_res;

    encoder_linearization_table_builder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // table builder state
    int         step_mean[STORE_DEPTH];
    int         load_idx;
    t_run_phase run_ph;
    bit         rising;
    int         wrap_at;
    int         wrap_ofs;
    int         cur_step;
    int         cur_sub;
    int         entry_cnt;
    t_err       run_err;

    t_pending   pending_q[$];
    t_out_item  expected_q[$];
    int         fail_cnt;
    bit         took;
    bit         calm_now;
    int         gap_left;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic int circ_delta(input int a, input int b);
        int d;
        d = a - b;
        if (d > HALF_LO) d -= ENC_COUNTS;
        if (d < -HALF_UP) d += ENC_COUNTS;
        return d;
    endfunction

    function automatic int circ_avg(input int a, input int b);
        int spread;
        int m;
        spread = (a > b) ? a - b : b - a;
        m = (a + b) >> 1;
        if (spread > HALF_LO) m = (m >= HALF_LO) ? m - HALF_LO : m + HALF_LO;
        return m;
    endfunction

    function automatic t_err validate_sweep();
        int d;
        int ad;
        int hits;
        int cur;
        int nxt;
        d = circ_delta(step_mean[0], step_mean[FULL_STEPS-1]);
        if (d == 0) return ERR_DIR;
        rising = (d > 0);
        for (int c = 1; c < FULL_STEPS; c++) begin
            d = circ_delta(step_mean[c], step_mean[c-1]);
            ad = (d < 0) ? -d : d;
            if (ad > DELTA_HI || ad < DELTA_LO) return ERR_CONT;
            if (d == 0) return ERR_DIR;
            if ((d > 0) != rising) return ERR_DIR;
        end
        hits = 0;
        for (int c = 0; c < FULL_STEPS; c++) begin
            cur = step_mean[c];
            nxt = step_mean[(c + 1) % FULL_STEPS];
            if (rising ? (nxt < cur) : (nxt > cur)) begin
                hits++;
                wrap_at = c;
                wrap_ofs = ENC_COUNTS - 1 - (rising ? cur : nxt);
            end
        end
        return (hits == 1) ? ERR_NONE : ERR_WRAP;
    endfunction

    function automatic int table_step(input int k);
        return rising ? wrap_at + k : wrap_at + FULL_STEPS - k;
    endfunction

    function automatic int step_span(input int k);
        int x;
        int a;
        int b;
        int d;
        x = table_step(k);
        a = step_mean[x % FULL_STEPS];
        b = step_mean[(x + 1) % FULL_STEPS];
        d = rising ? circ_delta(b, a) : circ_delta(a, b);
        return (d > 0) ? d : 0;
    endfunction

    function automatic void skip_empty();
        int d;
        int top;
        while (cur_step <= FULL_STEPS) begin
            d = step_span(cur_step);
            top = (d == 0) ? 0 : ((cur_step == FULL_STEPS) ? wrap_ofs : d);
            if (cur_sub < top) break;
            cur_step++;
            cur_sub = 0;
        end
    endfunction

    function automatic int table_value();
        int x;
        int d;
        int frac;
        int v;
        x = table_step(cur_step);
        d = step_span(cur_step);
        frac = (d != 0) ? (MICROSTEPS * cur_sub) / d : 0;
        v = rising ? MICROSTEPS * x + frac : MICROSTEPS * (x + 1) - frac;
        return (v % POS_TURN) & 16'hFFFF;
    endfunction

    function automatic t_out_item model_item(input t_in_item it);
        t_out_item r;
        r = '0;
        if (it.func == FUNC_LOAD) begin
            if (run_ph == PH_END) begin
                run_ph = PH_LOAD;
                load_idx = 0;
                run_err = ERR_NONE;
            end
            if (run_ph == PH_LOAD && load_idx < STORE_DEPTH) begin
                step_mean[load_idx] = circ_avg(int'(it.fwd_value), int'(it.bwd_value));
                load_idx++;
                if (load_idx >= STORE_DEPTH) begin
                    r.check_done = 1'b1;
                    run_err = validate_sweep();
                    run_ph = PH_END;
                    if (run_err == ERR_NONE) begin
                        run_ph = PH_EMIT;
                        cur_step = 0;
                        cur_sub = wrap_ofs;
                        entry_cnt = 0;
                        skip_empty();
                        if (cur_step > FULL_STEPS) begin
                            run_err = ERR_COUNT;
                            run_ph = PH_END;
                        end
                    end
                end
            end
        end else if (run_ph == PH_EMIT) begin
            r.entry = 16'(table_value());
            r.entry_valid = 1'b1;
            entry_cnt++;
            cur_sub++;
            skip_empty();
            if (cur_step > FULL_STEPS) begin
                r.last_entry = 1'b1;
                run_ph = PH_END;
                if (entry_cnt != ENC_COUNTS) run_err = ERR_COUNT;
            end
        end
        r.error_code = run_err;
        return r;
    endfunction

    // accept transfers, predict, and check results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            took = 1'b0;
        end else begin
            took = start && !busy;
            if (o_res_valid) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_res);
                    fail_cnt++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (o_res.entry !== exp_r.entry) begin
                        $display("%0t: entry exp %0d got %0d", $time, exp_r.entry,
                                 o_res.entry);
                        fail_cnt++;
                    end
                    if (o_res.entry_valid !== exp_r.entry_valid) begin
                        $display("%0t: entry_valid exp %0b got %0b", $time,
                                 exp_r.entry_valid, o_res.entry_valid);
                        fail_cnt++;
                    end
                    if (o_res.last_entry !== exp_r.last_entry) begin
                        $display("%0t: last_entry exp %0b got %0b", $time,
                                 exp_r.last_entry, o_res.last_entry);
                        fail_cnt++;
                    end
                    if (o_res.check_done !== exp_r.check_done) begin
                        $display("%0t: check_done exp %0b got %0b", $time,
                                 exp_r.check_done, o_res.check_done);
                        fail_cnt++;
                    end
                    if (o_res.error_code !== exp_r.error_code) begin
                        $display("%0t: error_code exp %0d got %0d", $time,
                                 exp_r.error_code, o_res.error_code);
                        fail_cnt++;
                    end
                end
            end
            if (took) expected_q.push_back(model_item(i_cmd));
        end
    end

    // command driver
    always @(negedge i_clk) begin
        t_pending p;
        if (i_rst_n && (!start || took)) begin
            if (took && !calm_now && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 11);
            if (gap_left > 0 && !calm_now) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_q.size() != 0) begin
                p = pending_q.pop_front();
                calm_now = p.calm;
                start <= 1'b1;
                i_cmd <= p.item;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic push_item(input logic fn, input int fwd, input int bwd, input bit calm);
        t_pending p;
        p.item.func = fn;
        p.item.fwd_value = VAL_W'(fwd);
        p.item.bwd_value = VAL_W'(bwd);
        p.calm = calm;
        pending_q.push_back(p);
    endtask

    // one sweep of FULL_STEPS+1 pairs; fault: 0 clean, 1 continuity, 2 direction, 3 noise
    task automatic push_sweep(input bit up, input int fault);
        int dl[FULL_STEPS];
        int tgt[STORE_DEPTH];
        int i;
        int j;
        int k;
        int c;
        int e;
        for (i = 0; i < FULL_STEPS; i++)
            dl[i] = NOM_COUNTS + ((i < ENC_COUNTS - NOM_COUNTS * FULL_STEPS) ? 1 : 0);
        repeat (150) begin
            i = $urandom_range(0, FULL_STEPS - 1);
            j = $urandom_range(0, FULL_STEPS - 1);
            k = $urandom_range(0, 30);
            if (dl[i] + k <= 117 && dl[j] - k >= 45) begin
                dl[i] += k;
                dl[j] -= k;
            end
        end
        tgt[0] = $urandom_range(0, ENC_COUNTS - 1);
        for (i = 1; i < FULL_STEPS; i++)
            tgt[i] = (tgt[i-1] + (up ? dl[i-1] : ENC_COUNTS - dl[i-1])) % ENC_COUNTS;
        tgt[FULL_STEPS] = $urandom_range(0, ENC_COUNTS - 1);
        c = $urandom_range(1, FULL_STEPS - 1);
        if (fault == 1) begin
            k = ($urandom_range(0, 1) != 0) ? $urandom_range(DELTA_HI + 1, 400)
                                            : $urandom_range(1, DELTA_LO - 1);
            tgt[c] = (tgt[c-1] + (up ? k : ENC_COUNTS - k)) % ENC_COUNTS;
        end else if (fault == 2) begin
            tgt[c] = (tgt[c-1] + (up ? ENC_COUNTS - 60 : 60)) % ENC_COUNTS;
        end
        for (i = 0; i < STORE_DEPTH; i++) begin
            if (fault == 3) begin
                push_item(FUNC_LOAD, $urandom_range(0, ENC_COUNTS - 1),
                          $urandom_range(0, ENC_COUNTS - 1), 1'b0);
            end else begin
                e = $urandom_range(0, 200);
                push_item(FUNC_LOAD, (tgt[i] + e) % ENC_COUNTS,
                          (tgt[i] - e + ENC_COUNTS) % ENC_COUNTS, 1'b0);
            end
            // a stray fetch mid-load gives no entry
            if ($urandom_range(0, 40) == 0)
                push_item(FUNC_FETCH, $urandom_range(0, ENC_COUNTS - 1),
                          $urandom_range(0, ENC_COUNTS - 1), 1'b0);
        end
    endtask

    initial begin
        int n_fetch;
        run_ph = PH_LOAD;
        load_idx = 0;
        rising = 1'b0;
        wrap_at = 0;
        wrap_ofs = 0;
        cur_step = 0;
        cur_sub = 0;
        entry_cnt = 0;
        run_err = ERR_NONE;
        fail_cnt = 0;
        took = 1'b0;
        calm_now = 1'b0;
        gap_left = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // field extremes, fetch while loading, then a flat sweep (no direction)
        push_item(FUNC_FETCH, ENC_COUNTS - 1, 0, 1'b0);
        push_item(FUNC_LOAD, 0, ENC_COUNTS - 1, 1'b0);
        push_item(FUNC_LOAD, ENC_COUNTS - 1, 0, 1'b0);
        push_item(FUNC_LOAD, ENC_COUNTS - 1, ENC_COUNTS - 1, 1'b0);
        push_item(FUNC_LOAD, 0, 0, 1'b0);
        push_item(FUNC_FETCH, 0, ENC_COUNTS - 1, 1'b0);
        for (int i = 4; i < STORE_DEPTH; i++) push_item(FUNC_LOAD, 5000, 5000, 1'b0);
        push_item(FUNC_FETCH, 0, 0, 1'b0);

        // hold off until the block has answered everything
        while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge i_clk);

        // clean sweep, then fetch part of the table; stray loads are ignored
        push_sweep($urandom_range(0, 1), 0);
        n_fetch = 90;
        for (int i = 0; i < n_fetch; i++) begin
            push_item(FUNC_FETCH, $urandom_range(0, ENC_COUNTS - 1),
                      $urandom_range(0, ENC_COUNTS - 1), i > n_fetch - 30);
            if ($urandom_range(0, 30) == 0)
                push_item(FUNC_LOAD, $urandom_range(0, ENC_COUNTS - 1),
                          $urandom_range(0, ENC_COUNTS - 1), 1'b0);
        end
        push_item(FUNC_LOAD, 123, 456, 1'b1);
        push_item(FUNC_FETCH, 0, 0, 1'b1);

        while (pending_q.size() != 0 || start || expected_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/eltb_pkg.sv
rtl/eltb_div.sv
rtl/encoder_linearization_table_builder.sv
verif/tb.sv
